// ===== rtl/dcg_pkg.sv =====
`timescale 1ns / 1ps

package dcg_pkg;

	localparam int DAY_W    = 22;
	localparam int YEAR_W   = 14;
	localparam int MONTH_W  = 4;
	localparam int DOM_W    = 5;
	localparam int WDAY_W   = 3;
	localparam int PACKED_W = 27;
	localparam int DOY_W    = 9;

	// split: 400/100/4-year and week divisions, year-in-block split, then date assembly
	localparam int SPLIT_STAGES = 8;
	localparam int BUILD_STAGES = 3;
	localparam int NUM_STAGES   = SPLIT_STAGES + BUILD_STAGES;

	localparam int DAYS_400Y   = 146097;
	localparam int DAYS_100Y   = 36524;
	localparam int DAYS_4Y     = 1461;
	localparam int DAYS_1Y     = 365;
	localparam int DAYS_LEAP_Y = 366;
	localparam int DAYS_WEEK   = 7;
	localparam int YEAR_SCALE  = 10000;
	localparam int MONTH_SCALE = 100;

	// floor(2^32 / d): estimate is exact or one short for any 22-bit dividend
	localparam int RECIP_SHIFT = 32;
	localparam logic [14:0] RECIP_400 = 15'((64'd1 << RECIP_SHIFT) / 64'(DAYS_400Y));
	localparam logic [16:0] RECIP_100 = 17'((64'd1 << RECIP_SHIFT) / 64'(DAYS_100Y));
	localparam logic [21:0] RECIP_4   = 22'((64'd1 << RECIP_SHIFT) / 64'(DAYS_4Y));
	localparam logic [29:0] RECIP_7   = 30'((64'd1 << RECIP_SHIFT) / 64'(DAYS_WEEK));

	// days before the first of each month, common year
	localparam logic [DOY_W-1:0] MONTH_START [12] = '{
		9'd0,   9'd31,  9'd59,  9'd90,  9'd120, 9'd151,
		9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
	};

	typedef logic [NUM_STAGES-1:0] stage_en_t;

	typedef struct packed {
		logic [4:0]       q400;
		logic [2:0]       q100;
		logic [4:0]       q4;
		logic [2:0]       q1;
		logic [DOY_W-1:0] rem1;
		logic [WDAY_W-1:0] wday;
		logic             zero;
	} split_t;

	typedef struct packed {
		logic [YEAR_W-1:0]   year;
		logic [MONTH_W-1:0]  month;
		logic [DOM_W-1:0]    day_of_month;
		logic [WDAY_W-1:0]   weekday;
		logic [PACKED_W-1:0] packed_date;
		logic                invalid;
	} date_t;

endpackage

// ===== rtl/dcg_in_if.sv =====
`timescale 1ns / 1ps

interface dcg_in_if
	import dcg_pkg::*;
();
	logic             valid;
	logic             ready;
	logic [DAY_W-1:0] day_count;

	modport source (output valid, output day_count, input ready);
	modport sink   (input valid, input day_count, output ready);
endinterface

// ===== rtl/dcg_out_if.sv =====
`timescale 1ns / 1ps

interface dcg_out_if
	import dcg_pkg::*;
();
	logic                valid;
	logic                ready;
	logic [YEAR_W-1:0]   year;
	logic [MONTH_W-1:0]  month;
	logic [DOM_W-1:0]    day_of_month;
	logic [WDAY_W-1:0]   weekday;
	logic [PACKED_W-1:0] packed_date;
	logic                invalid;

	modport source (output valid, output year, output month, output day_of_month,
		output weekday, output packed_date, output invalid, input ready);
	modport sink   (input valid, input year, input month, input day_of_month,
		input weekday, input packed_date, input invalid, output ready);
endinterface

// ===== rtl/dcg_pipe_ctrl.sv =====
`timescale 1ns / 1ps

module dcg_pipe_ctrl
	import dcg_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	output stage_en_t en
);

	logic [NUM_STAGES-1:0] vld_q;

	// a stage loads when it is empty or the one after it moves; bubbles collapse
	always_comb begin
		en[NUM_STAGES-1] = !vld_q[NUM_STAGES-1] || out_ready;
		for (int k = NUM_STAGES - 2; k >= 0; k--) begin
			en[k] = !vld_q[k] || en[k+1];
		end
	end

	assign in_ready  = en[0];
	assign out_valid = vld_q[NUM_STAGES-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[0]) begin
				vld_q[0] <= in_valid;
			end
			for (int k = 1; k < NUM_STAGES; k++) begin
				if (en[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

endmodule

// ===== rtl/dcg_cycle_split.sv =====
`timescale 1ns / 1ps

module dcg_cycle_split
	import dcg_pkg::*;
(
	input  logic                    clk,
	input  logic [SPLIT_STAGES-1:0] en,
	input  logic [DAY_W-1:0]        day_count,
	output split_t                  split
);

	// s1: n = count - 1
	logic [DAY_W-1:0] n_s1, cnt_s1;
	logic             zero_s1;

	// s2: quotient estimates
	logic [4:0]       q400e_s2;
	logic [19:0]      w7e_s2;
	logic [DAY_W-1:0] n_s2, cnt_s2;
	logic             zero_s2;

	// s3: 400-year split, weekday
	logic [17:0]       r400_s3;
	logic [4:0]        q400_s3;
	logic [WDAY_W-1:0] wday_s3;
	logic              zero_s3;

	// s4
	logic [2:0]        q100e_s4;
	logic [17:0]       r400_s4;
	logic [4:0]        q400_s4;
	logic [WDAY_W-1:0] wday_s4;
	logic              zero_s4;

	// s5: 100-year split
	logic [15:0]       r100_s5;
	logic [2:0]        q100_s5;
	logic [4:0]        q400_s5;
	logic [WDAY_W-1:0] wday_s5;
	logic              zero_s5;

	// s6
	logic [4:0]        q4e_s6;
	logic [15:0]       r100_s6;
	logic [2:0]        q100_s6;
	logic [4:0]        q400_s6;
	logic [WDAY_W-1:0] wday_s6;
	logic              zero_s6;

	// s7: 4-year split
	logic [10:0]       r4_s7;
	logic [4:0]        q4_s7;
	logic [2:0]        q100_s7;
	logic [4:0]        q400_s7;
	logic [WDAY_W-1:0] wday_s7;
	logic              zero_s7;

	// s8: year within 4-year block
	split_t split_s8;

	logic [36:0]      p400;
	logic [51:0]      p7;
	logic [DAY_W-1:0] t400, t7;
	logic [34:0]      p100;
	logic [17:0]      t100;
	logic [37:0]      p4;
	logic [15:0]      t4;
	logic [2:0]       q1;
	logic [10:0]      r1;

	assign p400 = 37'(n_s1) * 37'(RECIP_400);
	assign p7   = 52'(cnt_s1) * 52'(RECIP_7);
	assign t400 = n_s2 - 22'(q400e_s2) * 22'(DAYS_400Y);
	assign t7   = cnt_s2 - 22'(w7e_s2) * 22'(DAYS_WEEK);
	assign p100 = 35'(r400_s3) * 35'(RECIP_100);
	assign t100 = r400_s4 - 18'(q100e_s4) * 18'(DAYS_100Y);
	assign p4   = 38'(r100_s5) * 38'(RECIP_4);
	assign t4   = r100_s6 - 16'(q4e_s6) * 16'(DAYS_4Y);

	// year index reaches 4 only on the last day of a full 4-year block
	always_comb begin
		if (r4_s7 >= 11'(4 * DAYS_1Y)) begin
			q1 = 3'd4;
		end else if (r4_s7 >= 11'(3 * DAYS_1Y)) begin
			q1 = 3'd3;
		end else if (r4_s7 >= 11'(2 * DAYS_1Y)) begin
			q1 = 3'd2;
		end else if (r4_s7 >= 11'(DAYS_1Y)) begin
			q1 = 3'd1;
		end else begin
			q1 = 3'd0;
		end
		r1 = r4_s7 - 11'(q1) * 11'(DAYS_1Y);
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			n_s1    <= day_count - 22'd1;
			cnt_s1  <= day_count;
			zero_s1 <= (day_count == '0);
		end
		if (en[1]) begin
			q400e_s2 <= p400[36:32];
			w7e_s2   <= p7[51:32];
			n_s2     <= n_s1;
			cnt_s2   <= cnt_s1;
			zero_s2  <= zero_s1;
		end
		if (en[2]) begin
			if (t400 >= 22'(DAYS_400Y)) begin
				q400_s3 <= q400e_s2 + 5'd1;
				r400_s3 <= 18'(t400 - 22'(DAYS_400Y));
			end else begin
				q400_s3 <= q400e_s2;
				r400_s3 <= 18'(t400);
			end
			wday_s3 <= (t7 >= 22'(DAYS_WEEK)) ? 3'(t7 - 22'(DAYS_WEEK)) : 3'(t7);
			zero_s3 <= zero_s2;
		end
		if (en[3]) begin
			q100e_s4 <= p100[34:32];
			r400_s4  <= r400_s3;
			q400_s4  <= q400_s3;
			wday_s4  <= wday_s3;
			zero_s4  <= zero_s3;
		end
		if (en[4]) begin
			if (t100 >= 18'(DAYS_100Y)) begin
				q100_s5 <= q100e_s4 + 3'd1;
				r100_s5 <= 16'(t100 - 18'(DAYS_100Y));
			end else begin
				q100_s5 <= q100e_s4;
				r100_s5 <= 16'(t100);
			end
			q400_s5 <= q400_s4;
			wday_s5 <= wday_s4;
			zero_s5 <= zero_s4;
		end
		if (en[5]) begin
			q4e_s6  <= p4[36:32];
			r100_s6 <= r100_s5;
			q100_s6 <= q100_s5;
			q400_s6 <= q400_s5;
			wday_s6 <= wday_s5;
			zero_s6 <= zero_s5;
		end
		if (en[6]) begin
			if (t4 >= 16'(DAYS_4Y)) begin
				q4_s7 <= q4e_s6 + 5'd1;
				r4_s7 <= 11'(t4 - 16'(DAYS_4Y));
			end else begin
				q4_s7 <= q4e_s6;
				r4_s7 <= 11'(t4);
			end
			q100_s7 <= q100_s6;
			q400_s7 <= q400_s6;
			wday_s7 <= wday_s6;
			zero_s7 <= zero_s6;
		end
		if (en[7]) begin
			split_s8.q400 <= q400_s7;
			split_s8.q100 <= q100_s7;
			split_s8.q4   <= q4_s7;
			split_s8.q1   <= q1;
			split_s8.rem1 <= DOY_W'(r1);
			split_s8.wday <= wday_s7;
			split_s8.zero <= zero_s7;
		end
	end

	assign split = split_s8;

endmodule

// ===== rtl/dcg_date_build.sv =====
`timescale 1ns / 1ps

module dcg_date_build
	import dcg_pkg::*;
(
	input  logic                    clk,
	input  logic [BUILD_STAGES-1:0] en,
	input  split_t                  split,
	output date_t                   date
);

	// s9: year, day of year, leap
	logic [YEAR_W-1:0] year_s9;
	logic [DOY_W-1:0]  doy_s9;
	logic              leap_s9;
	logic [WDAY_W-1:0] wday_s9;
	logic              zero_s9;

	// s10: month, day, scaled year
	logic [YEAR_W-1:0]   year_s10;
	logic [PACKED_W-1:0] yscaled_s10;
	logic [MONTH_W-1:0]  month_s10;
	logic [DOM_W-1:0]    dom_s10;
	logic [WDAY_W-1:0]   wday_s10;
	logic                zero_s10;

	date_t date_s11;

	logic              closing;
	logic              leap;
	logic [YEAR_W-1:0] year;
	logic [MONTH_W-1:0] past;
	logic [DOY_W-1:0]  start_sel;

	// closing day of a 4- or 400-year cycle is Dec 31 of a leap year
	assign closing = (split.q100 == 3'd4) || (split.q1 == 3'd4);
	assign leap    = closing || ((split.q1 == 3'd3) && ((split.q4 != 5'd24) || (split.q100 == 3'd3)));
	assign year    = 14'(split.q400) * 14'(400) + 14'(split.q100) * 14'(100)
		+ 14'(split.q4) * 14'(4) + 14'(split.q1) + 14'(!closing);

	// count of month starts already passed
	always_comb begin
		past = '0;
		for (int k = 1; k < 12; k++) begin
			if (doy_s9 > MONTH_START[k] + DOY_W'(leap_s9 && (k >= 2))) begin
				past = past + 4'd1;
			end
		end
		start_sel = MONTH_START[past] + DOY_W'(leap_s9 && (past >= 4'd2));
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			year_s9 <= year;
			doy_s9  <= closing ? DOY_W'(DAYS_LEAP_Y) : split.rem1 + 9'd1;
			leap_s9 <= leap;
			wday_s9 <= split.wday;
			zero_s9 <= split.zero;
		end
		if (en[1]) begin
			year_s10    <= year_s9;
			yscaled_s10 <= 27'(year_s9) * 27'(YEAR_SCALE);
			month_s10   <= past + 4'd1;
			dom_s10     <= 5'(doy_s9 - start_sel);
			wday_s10    <= wday_s9;
			zero_s10    <= zero_s9;
		end
		if (en[2]) begin
			if (zero_s10) begin
				date_s11 <= '{year: '0, month: '0, day_of_month: '0, weekday: '0,
					packed_date: '0, invalid: 1'b1};
			end else begin
				date_s11.year         <= year_s10;
				date_s11.month        <= month_s10;
				date_s11.day_of_month <= dom_s10;
				date_s11.weekday      <= wday_s10;
				date_s11.packed_date  <= yscaled_s10 + 27'(month_s10) * 27'(MONTH_SCALE)
					+ 27'(dom_s10);
				date_s11.invalid      <= 1'b0;
			end
		end
	end

	assign date = date_s11;

endmodule

// ===== rtl/day_count_to_gregorian_date_unit.sv =====
`timescale 1ns / 1ps
// channel  dir  handshake     payload
// days     in   valid/ready   day_count[21:0] (1 = 0001-01-01)
// dates    out  valid/ready   year, month, day_of_month, weekday, packed_date, invalid
//
// One beat per cycle while dates is not stalled; an accepted beat passes through stages s1..s11.
// Depth is set by the chain of 400/100/4-year reciprocal divisions, two stages each
// (estimate multiply, then remainder and one-step correction), plus date assembly.
// arst_n clears only the stage valid bits; payload registers are not reset.
// A stall at dates holds each full stage; empty stages keep filling, so bubbles close up.

module day_count_to_gregorian_date_unit
	import dcg_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	dcg_in_if.sink    days,
	dcg_out_if.source dates
);

	stage_en_t en;
	split_t    split;
	date_t     date;

	// valid bits and per-stage load enables
	dcg_pipe_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (days.valid),
		.in_ready  (days.ready),
		.out_valid (dates.valid),
		.out_ready (dates.ready),
		.en        (en)
	);

	// s1..s8: count -> 400/100/4/1-year indices, remainder, weekday
	dcg_cycle_split u_split (
		.clk       (clk),
		.en        (en[SPLIT_STAGES-1:0]),
		.day_count (days.day_count),
		.split     (split)
	);

	// s9..s11: year, month table walk, packed decimal
	dcg_date_build u_build (
		.clk   (clk),
		.en    (en[NUM_STAGES-1:SPLIT_STAGES]),
		.split (split),
		.date  (date)
	);

	assign dates.year         = date.year;
	assign dates.month        = date.month;
	assign dates.day_of_month = date.day_of_month;
	assign dates.weekday      = date.weekday;
	assign dates.packed_date  = date.packed_date;
	assign dates.invalid      = date.invalid;

endmodule

// ===== rtl/dcg_checker.sv =====
`timescale 1ns / 1ps

module dcg_checker
	import dcg_pkg::*;
(
	input logic                clk,
	input logic                arst_n,
	input logic                out_valid,
	input logic                out_ready,
	input logic [YEAR_W-1:0]   year,
	input logic [MONTH_W-1:0]  month,
	input logic [DOM_W-1:0]    day_of_month,
	input logic [WDAY_W-1:0]   weekday,
	input logic [PACKED_W-1:0] packed_date,
	input logic                invalid
);

	logic [PACKED_W-1:0] packed_calc;

	assign packed_calc = 27'(year) * 27'(YEAR_SCALE) + 27'(month) * 27'(MONTH_SCALE)
		+ 27'(day_of_month);

	// stalled result beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(packed_date) && $stable(invalid))
		else $error("result beat changed under stall");

	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && invalid |-> year == '0 && month == '0 && day_of_month == '0
			&& weekday == '0 && packed_date == '0)
		else $error("invalid beat carries nonzero fields");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !invalid |-> month >= 4'd1 && month <= 4'd12 && day_of_month >= 5'd1
			&& weekday <= 3'd6 && year != '0)
		else $error("date field out of range");

	a_pack: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !invalid |-> packed_date == packed_calc)
		else $error("packed date disagrees with fields");

endmodule

bind day_count_to_gregorian_date_unit dcg_checker u_dcg_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (dates.valid),
	.out_ready    (dates.ready),
	.year         (dates.year),
	.month        (dates.month),
	.day_of_month (dates.day_of_month),
	.weekday      (dates.weekday),
	.packed_date  (dates.packed_date),
	.invalid      (dates.invalid)
);
